// ===== src/stb_pkg.sv =====
// shared types and codes for the software timer bank
package stb_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RUN_IDLE  = 2'd0,
    RUN_START = 2'd1,
    RUN_STOP  = 2'd2
  } run_t;

  localparam int unsigned ID_W = 8;
  localparam int unsigned RELOAD_W = 16;

endpackage

// ===== src/software_timer_bank_top.sv =====
// software timer bank: slot memory with a one-slot-per-cycle walker that pauses on a full output
//
//  channel | direction | handshake             | fields
//  --------+-----------+-----------------------+---------------------------------------------
//  in      | sink      | in_valid / in_ready   | operation, timer_id, reload_ticks, one_shot
//  out     | source    | out_valid / out_ready | expired_id, last_expiry
//
// create writes the next free slot; start and stop search the filled slots in order, one slot a
// cycle, and stop at the first match. a tick walks every filled slot through the slot memory,
// one read-modify-write a cycle, then flushes the held expiry word. the walk pauses on an expiry
// while the output register and the held word are both full.
// reset empties the bank at once through the fill count; no clearing pass.
module software_timer_bank_top #(
  parameter int unsigned NUM_TIMERS = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  stb_pkg::op_t                     operation,
  input  logic [stb_pkg::ID_W-1:0]         timer_id,
  input  logic [stb_pkg::RELOAD_W-1:0]     reload_ticks,
  input  logic                             one_shot,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [stb_pkg::ID_W-1:0]         expired_id,
  output logic                             last_expiry
);
  import stb_pkg::*;

  localparam int unsigned IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned FILL_W = $clog2(NUM_TIMERS + 1);

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [COUNT_BITS-1:0] reload;
    logic [COUNT_BITS-1:0] count;
    run_t                  run;
    logic                  once;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_WALK,
    S_FLUSH
  } state_t;

  slot_t mem [NUM_TIMERS];
  slot_t rdata;
  slot_t wdata;
  logic  we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] rd_addr;

  state_t state, state_next;
  logic [FILL_W-1:0] filled, filled_next;
  logic [IDX_W-1:0]  cur, cur_next;
  run_t              cmd_run, cmd_run_next;
  logic [ID_W-1:0]   cmd_id, cmd_id_next;
  logic              pend_valid, pend_valid_next;
  logic [ID_W-1:0]   pend_id, pend_id_next;
  logic              out_valid_next;
  logic [ID_W-1:0]   expired_id_next;
  logic              last_expiry_next;

  logic out_free;
  logic last_slot;
  logic hit;
  logic [COUNT_BITS-1:0] new_reload;

  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign last_slot  = (FILL_W'(cur) == (filled - FILL_W'(1)));
  assign hit        = (rdata.run == RUN_START) && (rdata.count == '0);
  assign new_reload = COUNT_BITS'(reload_ticks);

  // slot memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    state_next       = state;
    filled_next      = filled;
    cur_next         = cur;
    cmd_run_next     = cmd_run;
    cmd_id_next      = cmd_id;
    pend_valid_next  = pend_valid;
    pend_id_next     = pend_id;
    out_valid_next   = out_valid && !out_ready;
    expired_id_next  = expired_id;
    last_expiry_next = last_expiry;
    we               = 1'b0;
    waddr            = cur;
    wdata            = rdata;
    rd_addr          = cur;

    case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (in_valid) begin
          case (operation)
            OP_CREATE: begin
              if (filled < FILL_W'(NUM_TIMERS)) begin
                we          = 1'b1;
                waddr       = filled[IDX_W-1:0];
                wdata       = '{id: timer_id, reload: new_reload, count: new_reload,
                                run: RUN_IDLE, once: one_shot};
                filled_next = filled + FILL_W'(1);
              end
            end
            OP_START, OP_STOP: begin
              cmd_run_next = (operation == OP_START) ? RUN_START : RUN_STOP;
              cmd_id_next  = timer_id;
              cur_next     = '0;
              if (filled != '0) begin
                state_next = S_SEARCH;
              end
            end
            OP_TICK: begin
              cur_next = '0;
              if (filled != '0) begin
                state_next = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      S_SEARCH: begin
        if (rdata.id == cmd_id) begin
          we         = 1'b1;
          wdata.run  = cmd_run;
          state_next = S_IDLE;
        end else if (last_slot) begin
          state_next = S_IDLE;
        end else begin
          cur_next = cur + IDX_W'(1);
          rd_addr  = cur + IDX_W'(1);
        end
      end

      S_WALK: begin
        if (!(hit && pend_valid && !out_free)) begin
          we = 1'b1;
          case (rdata.run)
            RUN_START: begin
              if (hit) begin
                wdata.count = rdata.reload;
                if (rdata.once) begin
                  wdata.run = RUN_IDLE;
                end
                if (pend_valid) begin
                  out_valid_next   = 1'b1;
                  expired_id_next  = pend_id;
                  last_expiry_next = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_id_next    = rdata.id;
              end else begin
                wdata.count = rdata.count - COUNT_BITS'(1);
              end
            end
            RUN_STOP: wdata.count = rdata.reload;
            default: ;
          endcase
          if (last_slot) begin
            state_next = S_FLUSH;
          end else begin
            cur_next = cur + IDX_W'(1);
            rd_addr  = cur + IDX_W'(1);
          end
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_valid_next   = 1'b1;
          expired_id_next  = pend_id;
          last_expiry_next = 1'b1;
          pend_valid_next  = 1'b0;
          state_next       = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      filled     <= '0;
      cur        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      filled     <= filled_next;
      cur        <= cur_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
    cmd_run     <= cmd_run_next;
    cmd_id      <= cmd_id_next;
    pend_id     <= pend_id_next;
    expired_id  <= expired_id_next;
    last_expiry <= last_expiry_next;
  end

endmodule

// ===== sim/software_timer_bank_top_tb.sv =====
// self-checking testbench for the software timer bank: directed and random words
`timescale 1ns / 100ps

module software_timer_bank_top_tb;
  import stb_pkg::*;

  localparam int unsigned NUM_TIMERS = 8;
  localparam int unsigned COUNT_BITS = 16;

  typedef struct {
    op_t                 op;
    logic [ID_W-1:0]     id;
    logic [RELOAD_W-1:0] reload;
    logic                once;
    bit                  drain;
  } timer_word_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            is_last;
  } expiry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid = 1'b0;
  logic                in_ready;
  op_t                 operation = OP_TICK;
  logic [ID_W-1:0]     timer_id = '0;
  logic [RELOAD_W-1:0] reload_ticks = '0;
  logic                one_shot = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ID_W-1:0]     expired_id;
  logic                last_expiry;

  software_timer_bank_top #(
    .NUM_TIMERS(NUM_TIMERS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .timer_id(timer_id),
    .reload_ticks(reload_ticks),
    .one_shot(one_shot),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .expired_id(expired_id),
    .last_expiry(last_expiry)
  );

  always #1 clk = ~clk;

  // own copy of the slot bank
  logic                  bank_used   [NUM_TIMERS];
  logic [ID_W-1:0]       bank_id     [NUM_TIMERS];
  logic [COUNT_BITS-1:0] bank_reload [NUM_TIMERS];
  logic [COUNT_BITS-1:0] bank_count  [NUM_TIMERS];
  run_t                  bank_run    [NUM_TIMERS];
  logic                  bank_once   [NUM_TIMERS];
  int unsigned           bank_fill = 0;

  timer_word_t pending_words[$];
  expiry_t     expiry_q[$];
  expiry_t     want;

  int unsigned words_total = 0;
  int unsigned words_accepted = 0;
  int unsigned ticks_sent = 0;
  int unsigned expiries_seen = 0;
  int unsigned creates_dropped = 0;
  int unsigned errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      bank_used[i] = 1'b0;
    end
  end

  task automatic apply_word(input op_t op, input logic [ID_W-1:0] id,
                            input logic [RELOAD_W-1:0] rl, input logic once);
    bit      found;
    int      n;
    expiry_t e;
    found = 1'b0;
    n = 0;
    case (op)
      OP_CREATE: begin
        if (bank_fill < NUM_TIMERS) begin
          bank_used[bank_fill]   = 1'b1;
          bank_id[bank_fill]     = id;
          bank_reload[bank_fill] = rl[COUNT_BITS-1:0];
          bank_count[bank_fill]  = rl[COUNT_BITS-1:0];
          bank_run[bank_fill]    = RUN_IDLE;
          bank_once[bank_fill]   = once;
          bank_fill++;
        end else begin
          creates_dropped++;
        end
      end
      OP_START, OP_STOP: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!found && bank_used[i] && bank_id[i] == id) begin
            bank_run[i] = (op == OP_START) ? RUN_START : RUN_STOP;
            found = 1'b1;
          end
        end
      end
      default: begin
        ticks_sent++;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (bank_used[i]) begin
            if (bank_run[i] == RUN_START) begin
              if (bank_count[i] == '0) begin
                bank_count[i] = bank_reload[i];
                e.id = bank_id[i];
                e.is_last = 1'b0;
                expiry_q.push_back(e);
                n++;
                if (bank_once[i]) begin
                  bank_run[i] = RUN_IDLE;
                end
              end else begin
                bank_count[i] = bank_count[i] - COUNT_BITS'(1);
              end
            end else if (bank_run[i] == RUN_STOP) begin
              bank_count[i] = bank_reload[i];
            end
          end
        end
        if (n > 0) begin
          expiry_q[expiry_q.size() - 1].is_last = 1'b1;
        end
      end
    endcase
  endtask

  task automatic push_word(input op_t op, input logic [ID_W-1:0] id,
                           input logic [RELOAD_W-1:0] rl, input logic once,
                           input bit drain = 1'b0);
    timer_word_t w;
    w.op = op;
    w.id = id;
    w.reload = rl;
    w.once = once;
    w.drain = drain;
    pending_words.push_back(w);
    words_total++;
  endtask

  function automatic bit known_id(input logic [ID_W-1:0] id);
    return id inside {8'd0, 8'd255, 8'd7, 8'hAA, 8'h55, 8'h0F, 8'hF0};
  endfunction

  task automatic want_word_out();
    timer_word_t w;
    w = pending_words.pop_front();
    in_valid     <= 1'b1;
    operation    <= w.op;
    timer_id     <= w.id;
    reload_ticks <= w.reload;
    one_shot     <= w.once;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap_left <= $urandom_range(1, 3);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      calm = (pending_words.size() < 30);
      if (in_valid && in_ready) begin
        apply_word(operation, timer_id, reload_ticks, one_shot);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain && expiry_q.size() != 0)) begin
          want_word_out();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expiry_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual expired_id %0d last_expiry %0b",
                   $time, expired_id, last_expiry);
        end else begin
          want = expiry_q.pop_front();
          expiries_seen++;
          if (expired_id !== want.id) begin
            errors++;
            $display("%0t: expired_id mismatch, expected %0d, actual %0d",
                     $time, want.id, expired_id);
          end
          if (last_expiry !== want.is_last) begin
            errors++;
            $display("%0t: last_expiry mismatch, expected %0b, actual %0b",
                     $time, want.is_last, last_expiry);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #200000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned     useful;
    int unsigned     pick;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] pool [7];
    pool = '{8'd0, 8'd255, 8'd7, 8'hAA, 8'h55, 8'h0F, 8'hF0};

    // directed
    push_word(OP_TICK,   8'd0,   16'd0,     1'b0);
    push_word(OP_CREATE, 8'd0,   16'd0,     1'b0);
    push_word(OP_CREATE, 8'd255, 16'hFFFF,  1'b1);
    push_word(OP_CREATE, 8'd7,   16'd1,     1'b1);
    push_word(OP_CREATE, 8'd7,   16'd2,     1'b0);
    push_word(OP_START,  8'd0,   16'd0,     1'b0);
    push_word(OP_START,  8'd7,   16'd0,     1'b0);
    push_word(OP_TICK,   8'd0,   16'd0,     1'b0);
    push_word(OP_TICK,   8'd0,   16'd0,     1'b0);
    push_word(OP_START,  8'd7,   16'd0,     1'b0);
    push_word(OP_STOP,   8'd0,   16'd0,     1'b0);
    push_word(OP_TICK,   8'd0,   16'd0,     1'b0);
    push_word(OP_START,  8'd255, 16'd0,     1'b0);
    push_word(OP_TICK,   8'd0,   16'd0,     1'b0,  1'b1);
    push_word(OP_STOP,   8'd99,  16'd0,     1'b0);
    push_word(OP_CREATE, 8'hAA,  16'd3,     1'b0);
    push_word(OP_CREATE, 8'h55,  16'd0,     1'b1);
    push_word(OP_CREATE, 8'h0F,  16'd5,     1'b0);
    push_word(OP_CREATE, 8'hF0,  16'd2,     1'b1);
    push_word(OP_CREATE, 8'h33,  16'hAAAA,  1'b1);
    push_word(OP_START,  8'hAA,  16'd0,     1'b0);
    push_word(OP_START,  8'h55,  16'd0,     1'b0);
    push_word(OP_START,  8'h0F,  16'd0,     1'b0);
    push_word(OP_START,  8'hF0,  16'd0,     1'b0);
    push_word(OP_START,  8'd0,   16'd0,     1'b0);
    push_word(OP_TICK,   8'd0,   16'd0,     1'b0);

    // random, bank already full so creates are dropped
    useful = 0;
    while (words_total < 210) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_word(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), useful == 0 || useful == 105);
        useful++;
      end else if (pick < 84) begin
        id = pool[$urandom_range(0, 6)];
        push_word((pick < 72) ? OP_START : OP_STOP, id, 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
        useful++;
      end else if (pick < 92) begin
        id = 8'($urandom_range(0, 255));
        push_word((pick < 88) ? OP_START : OP_STOP, id, 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
        if (known_id(id)) begin
          useful++;
        end
      end else begin
        push_word(OP_CREATE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (words_accepted != words_total) @(posedge clk);
    while (expiry_q.size() != 0) @(posedge clk);
    repeat (4 * NUM_TIMERS) @(posedge clk);

    if (expiry_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expiry words never arrived", $time, expiry_q.size());
    end
    $display("summary: %0d words sent, %0d ticks, %0d expiry words checked",
             words_accepted, ticks_sent, expiries_seen);
    $display("summary: %0d creates dropped on a full bank, %0d errors",
             creates_dropped, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
